### src/rtn_pkg.sv
// ----------------------------------------------------------------------------
// rtn_pkg: shared types and constants of the nearest-hit block
// Number formats, working widths, margins and the controller state type.
// ----------------------------------------------------------------------------
package rtn_pkg;

	localparam int SURFACE_COUNT   = 4096;
	localparam int COORD_FRAC_BITS = 16;
	localparam int DIR_FRAC_BITS   = 30;

	// Working widths: edges and offsets, multiplier operand, accumulator.
	localparam int EW  = 33;
	localparam int YW  = 34;
	localparam int W   = 112;
	// Divider numerator and quotient width, one quotient bit per step.
	localparam int NW  = 34 + DIR_FRAC_BITS;
	// Integer square root of the squared length.
	localparam int SQ_W  = 68;
	localparam int LEN_W = 34;
	localparam int REM_W = 35;

	localparam logic [63:0] MARGIN =
		((64'd1 << COORD_FRAC_BITS) + 64'd999999) / 64'd1000000;
	localparam logic [127:0] A_LIMIT_FULL =
		((128'd1 << (DIR_FRAC_BITS + 2 * COORD_FRAC_BITS)) + 128'd999999999)
		/ 128'd1000000000;
	localparam logic [W-1:0] A_LIMIT = A_LIMIT_FULL[W-1:0];

	typedef struct packed {
		logic start;
		logic clear;
		logic neg;
	} mac_cmd_t;

	typedef struct packed {
		logic start;
	} div_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_ABS,
		ST_CHK_A,
		ST_CHK_U,
		ST_CHK_V,
		ST_CHK_T,
		ST_DIV,
		ST_UPD,
		ST_SQRT,
		ST_RDIV,
		ST_FIN
	} state_t;

	function automatic logic [1:0] next3(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

endpackage

### src/ray_triangle_nearest_hit.sv
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit: nearest obstruction along a segment
// Loads segments, tests triangles against them and reports the nearest hit.
// ----------------------------------------------------------------------------
// Every transaction on the input channel gives one transaction on the output
// channel carrying the running answer. A ray transaction (func 0) forms the
// squared length on the serial multiplier, takes its square root and then
// runs three normalising divisions; a zero-length segment skips all of this.
// A triangle transaction (func 1) runs 24 products through the serial
// multiply-accumulate unit (cross products, then dot products), fixes the
// sign, makes four checks and divides in the restoring divider; one that is
// rejected early finishes sooner, and one with a bad or skipped surface
// index skips all of this. The multiplier retires one operand bit per cycle.
// The block takes one transaction at a time; a finished result waits in the
// output register, and the next input is accepted meanwhile.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [31:0] pt_a_x,
	input  logic signed [31:0] pt_a_y,
	input  logic signed [31:0] pt_a_z,
	input  logic signed [31:0] pt_b_x,
	input  logic signed [31:0] pt_b_y,
	input  logic signed [31:0] pt_b_z,
	input  logic signed [31:0] pt_c_x,
	input  logic signed [31:0] pt_c_y,
	input  logic signed [31:0] pt_c_z,
	input  logic signed [12:0] surface_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit_found,
	output logic [11:0]        hit_surface,
	output logic [30:0]        hit_distance
);
	localparam int W   = rtn_pkg::W;
	localparam int EW  = rtn_pkg::EW;
	localparam int YW  = rtn_pkg::YW;
	localparam int NW  = rtn_pkg::NW;
	localparam int D   = rtn_pkg::DIR_FRAC_BITS;
	localparam logic [31:0] DIR_ONE = 32'd1 << D;

	// Architectural state of the current segment.
	logic signed [31:0]   origin_q [3];
	logic signed [31:0]   dir_q [3];
	logic [31:0]          nearest_q;
	logic [11:0]          surf_q;
	logic                 hit_q;
	logic [12:0]          skip_q;
	logic                 usable_q;

	// Controller.
	rtn_pkg::state_t      state_q, state_d;
	logic [3:0]           grp_q;
	logic [1:0]           term_q;
	logic                 issued_q;
	logic                 ray_q;
	logic                 an_q;
	logic [5:0]           cnt_q;

	// Working registers.
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [EW-1:0] s_q [3];
	logic [EW-1:0]        mag_q [3];
	logic                 dneg_q [3];
	logic signed [W-1:0]  h_q [3];
	logic signed [W-1:0]  qv_q [3];
	logic signed [W-1:0]  a_q, u_q, v_q, t_q;
	logic [rtn_pkg::SQ_W-1:0]  sq_q;
	logic [rtn_pkg::REM_W-1:0] rem_q;
	logic [rtn_pkg::LEN_W-1:0] root_q;
	// Surface index of the triangle under test, kept from its transaction.
	logic [11:0]          tri_surf_q;

	// Output register.
	logic                 out_valid_q;
	logic                 hit_found_q;
	logic [11:0]          hit_surface_q;
	logic [30:0]          hit_distance_q;

	// Unit interfaces.
	rtn_pkg::mac_cmd_t    mac_cmd;
	rtn_pkg::div_cmd_t    div_cmd;
	logic signed [W-1:0]  mac_x;
	logic [YW-1:0]        mac_y;
	logic                 mac_done;
	logic signed [W-1:0]  mac_acc;
	logic [W-1:0]         div_r0;
	logic [NW-1:0]        div_n;
	logic [W-1:0]         div_d;
	logic                 div_done;
	logic [NW-1:0]        div_q;

	logic signed [31:0]   pa [3];
	logic signed [31:0]   pb [3];
	logic signed [31:0]   pc [3];
	logic signed [EW-1:0] dseg [3];
	logic                 any_len;
	logic                 tri_bad;
	logic                 accept;
	logic                 last_term;
	logic [1:0]           gi, gj, gk;
	logic                 reject;
	logic                 upd_ok;
	logic [31:0]          dir_mag;
	logic [rtn_pkg::REM_W+1:0] rem2, trial;
	logic                 sq_ge;

	assign pa[0] = pt_a_x; assign pa[1] = pt_a_y; assign pa[2] = pt_a_z;
	assign pb[0] = pt_b_x; assign pb[1] = pt_b_y; assign pb[2] = pt_b_z;
	assign pc[0] = pt_c_x; assign pc[1] = pt_c_y; assign pc[2] = pt_c_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dseg[i] = EW'(pb[i]) - EW'(pa[i]);
		end
	end

	assign any_len = (dseg[0] != '0) || (dseg[1] != '0) || (dseg[2] != '0);

	// A triangle is skipped outright for a bad or excluded surface index,
	// or when no usable segment has been loaded.
	assign tri_bad = surface_index[12]
		|| ({19'd0, surface_index} >= 32'(rtn_pkg::SURFACE_COUNT))
		|| (surface_index == skip_q) || !usable_q;

	assign accept = in_valid && in_ready;

	// Cross products take two terms per component, dot products three.
	assign last_term = (ray_q || grp_q >= 4'd6) ? (term_q == 2'd2) : (term_q == 2'd1);
	assign gi = (grp_q < 4'd3) ? grp_q[1:0] : 2'(grp_q - 4'd3);
	assign gj = rtn_pkg::next3(gi);
	assign gk = rtn_pkg::next3(gj);

	// Operand selection for the multiply-accumulate unit.
	always_comb begin
		mac_x = '0;
		mac_y = '0;
		if (ray_q) begin
			mac_x = W'(mag_q[term_q]);
			mac_y = YW'(mag_q[term_q]);
		end else begin
			priority if (grp_q < 4'd3) begin
				if (term_q == 2'd0) begin
					mac_x = W'(dir_q[gj]);
					mac_y = YW'(e2_q[gk]);
				end else begin
					mac_x = W'(dir_q[gk]);
					mac_y = YW'(e2_q[gj]);
				end
			end else if (grp_q < 4'd6) begin
				if (term_q == 2'd0) begin
					mac_x = W'(s_q[gj]);
					mac_y = YW'(e1_q[gk]);
				end else begin
					mac_x = W'(s_q[gk]);
					mac_y = YW'(e1_q[gj]);
				end
			end else if (grp_q == 4'd6) begin
				mac_x = h_q[term_q];
				mac_y = YW'(e1_q[term_q]);
			end else if (grp_q == 4'd7) begin
				mac_x = h_q[term_q];
				mac_y = YW'(s_q[term_q]);
			end else if (grp_q == 4'd8) begin
				mac_x = qv_q[term_q];
				mac_y = YW'(dir_q[term_q]);
			end else begin
				mac_x = qv_q[term_q];
				mac_y = YW'(e2_q[term_q]);
			end
		end
	end

	// Divider operands: the normalising division rounds by adding half the
	// length; the hit distance divides t scaled by the direction format.
	always_comb begin
		if (ray_q) begin
			div_r0 = '0;
			div_n  = (NW'(mag_q[term_q]) << D) + NW'(root_q >> 1);
			div_d  = W'(root_q);
		end else begin
			div_r0 = W'(t_q >>> 34);
			div_n  = {t_q[33:0], {D{1'b0}}};
			div_d  = a_q;
		end
	end

	assign upd_ok = (65'(div_q) >= 65'(rtn_pkg::MARGIN))
		&& ((65'(div_q) + 65'(rtn_pkg::MARGIN)) < 65'(nearest_q));

	assign dir_mag = (32'(div_q) > DIR_ONE) ? DIR_ONE : 32'(div_q);

	// One step of the digit-by-digit square root.
	assign rem2  = {rem_q, sq_q[rtn_pkg::SQ_W-1 -: 2]};
	assign trial = (rtn_pkg::REM_W+2)'({root_q, 2'b01});
	assign sq_ge = (rem2 >= trial);

	// Next state and unit commands.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mac_cmd  = '0;
		div_cmd  = '0;
		reject   = 1'b0;
		unique case (state_q)
			rtn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!func) begin
						state_d = any_len ? rtn_pkg::ST_MAC : rtn_pkg::ST_FIN;
					end else begin
						state_d = tri_bad ? rtn_pkg::ST_FIN : rtn_pkg::ST_MAC;
					end
				end
			end
			rtn_pkg::ST_MAC: begin
				if (!issued_q) begin
					mac_cmd.start = 1'b1;
					mac_cmd.clear = (term_q == 2'd0);
					mac_cmd.neg   = (!ray_q && grp_q < 4'd6 && term_q == 2'd1)
						|| (!ray_q && grp_q > 4'd6 && an_q);
				end else if (mac_done && last_term) begin
					if (ray_q) begin
						state_d = rtn_pkg::ST_SQRT;
					end else if (grp_q == 4'd9) begin
						state_d = rtn_pkg::ST_ABS;
					end
				end
			end
			rtn_pkg::ST_ABS: state_d = rtn_pkg::ST_CHK_A;
			rtn_pkg::ST_CHK_A: begin
				reject  = ($unsigned(a_q) < rtn_pkg::A_LIMIT);
				state_d = reject ? rtn_pkg::ST_FIN : rtn_pkg::ST_CHK_U;
			end
			rtn_pkg::ST_CHK_U: begin
				reject  = u_q[W-1] || (u_q > a_q);
				state_d = reject ? rtn_pkg::ST_FIN : rtn_pkg::ST_CHK_V;
			end
			rtn_pkg::ST_CHK_V: begin
				reject  = v_q[W-1] || ((u_q + v_q) > a_q);
				state_d = reject ? rtn_pkg::ST_FIN : rtn_pkg::ST_CHK_T;
			end
			rtn_pkg::ST_CHK_T: begin
				// The quotient t / a must stay below 2^33.
				reject  = t_q[W-1] || (t_q == '0) || ((t_q >>> 33) >= a_q);
				state_d = reject ? rtn_pkg::ST_FIN : rtn_pkg::ST_DIV;
			end
			rtn_pkg::ST_DIV: begin
				if (!issued_q) begin
					div_cmd.start = 1'b1;
				end else if (div_done) begin
					state_d = rtn_pkg::ST_UPD;
				end
			end
			rtn_pkg::ST_UPD: state_d = rtn_pkg::ST_FIN;
			rtn_pkg::ST_SQRT: begin
				if (cnt_q == 6'(rtn_pkg::LEN_W - 1)) begin
					state_d = rtn_pkg::ST_RDIV;
				end
			end
			rtn_pkg::ST_RDIV: begin
				if (!issued_q) begin
					div_cmd.start = 1'b1;
				end else if (div_done && term_q == 2'd2) begin
					state_d = rtn_pkg::ST_FIN;
				end
			end
			rtn_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = rtn_pkg::ST_IDLE;
				end
			end
			default: state_d = rtn_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and segment state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				origin_q[i] <= '0;
				dir_q[i]    <= '0;
			end
			nearest_q   <= '0;
			surf_q      <= '0;
			hit_q       <= 1'b0;
			skip_q      <= 13'h1FFF;
			usable_q    <= 1'b0;
			grp_q       <= '0;
			term_q      <= '0;
			issued_q    <= 1'b0;
			ray_q       <= 1'b0;
			an_q        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A finished result may replace the one leaving in the same cycle.
			if (state_q == rtn_pkg::ST_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mac_cmd.start || div_cmd.start) begin
				issued_q <= 1'b1;
			end
			unique case (state_q)
				rtn_pkg::ST_IDLE: begin
					if (accept) begin
						grp_q  <= '0;
						term_q <= '0;
						ray_q  <= !func;
						if (!func) begin
							for (int i = 0; i < 3; i++) begin
								origin_q[i] <= pa[i];
								if (!any_len) begin
									dir_q[i] <= '0;
								end
							end
							if (!any_len) begin
								nearest_q <= '0;
							end
							hit_q    <= 1'b0;
							surf_q   <= '0;
							skip_q   <= surface_index;
							usable_q <= any_len;
						end
					end
				end
				rtn_pkg::ST_MAC: begin
					if (issued_q && mac_done) begin
						issued_q <= 1'b0;
						if (last_term) begin
							term_q <= '0;
							grp_q  <= grp_q + 4'd1;
							if (!ray_q && grp_q == 4'd6) begin
								an_q <= mac_acc[W-1];
							end
							if (ray_q) begin
								cnt_q <= '0;
							end
						end else begin
							term_q <= term_q + 2'd1;
						end
					end
				end
				rtn_pkg::ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
				end
				rtn_pkg::ST_DIV: begin
					if (issued_q && div_done) begin
						issued_q <= 1'b0;
					end
				end
				rtn_pkg::ST_UPD: begin
					if (upd_ok) begin
						nearest_q <= 32'(div_q);
						surf_q    <= tri_surf_q;
						hit_q     <= 1'b1;
					end
				end
				rtn_pkg::ST_RDIV: begin
					if (issued_q && div_done) begin
						issued_q       <= 1'b0;
						term_q         <= term_q + 2'd1;
						dir_q[term_q]  <= dneg_q[term_q] ? -$signed(dir_mag) : $signed(dir_mag);
						if (term_q == 2'd2) begin
							nearest_q <= (root_q[rtn_pkg::LEN_W-1:32] != '0) ? '1
								: root_q[31:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working datapath registers; these need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			tri_surf_q <= surface_index[11:0];
			for (int i = 0; i < 3; i++) begin
				e1_q[i]   <= EW'(pb[i]) - EW'(pa[i]);
				e2_q[i]   <= EW'(pc[i]) - EW'(pa[i]);
				s_q[i]    <= EW'(origin_q[i]) - EW'(pa[i]);
				mag_q[i]  <= dseg[i][EW-1] ? EW'(-dseg[i]) : EW'(dseg[i]);
				dneg_q[i] <= dseg[i][EW-1];
			end
		end
		if (state_q == rtn_pkg::ST_MAC && issued_q && mac_done && last_term) begin
			if (ray_q) begin
				sq_q   <= mac_acc[rtn_pkg::SQ_W-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end else begin
				unique case (grp_q)
					4'd0, 4'd1, 4'd2: h_q[gi]  <= mac_acc;
					4'd3, 4'd4, 4'd5: qv_q[gi] <= mac_acc;
					4'd6:             a_q      <= mac_acc;
					4'd7:             u_q      <= mac_acc;
					4'd8:             v_q      <= mac_acc;
					default:          t_q      <= mac_acc;
				endcase
			end
		end
		if (state_q == rtn_pkg::ST_ABS && an_q) begin
			a_q <= -a_q;
		end
		if (state_q == rtn_pkg::ST_SQRT) begin
			rem_q  <= sq_ge ? rtn_pkg::REM_W'(rem2 - trial) : rtn_pkg::REM_W'(rem2);
			root_q <= {root_q[rtn_pkg::LEN_W-2:0], sq_ge};
			sq_q   <= sq_q << 2;
		end
		if (state_q == rtn_pkg::ST_FIN && (!out_valid_q || out_ready)) begin
			hit_found_q    <= hit_q;
			hit_surface_q  <= surf_q;
			hit_distance_q <= nearest_q[31] ? '1 : nearest_q[30:0];
		end
	end

	rtn_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.x      (mac_x),
		.y      (mac_y),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	rtn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.r0     (div_r0),
		.n      (div_n),
		.d      (div_d),
		.done   (div_done),
		.q      (div_q)
	);

	assign out_valid    = out_valid_q;
	assign hit_found    = hit_found_q;
	assign hit_surface  = hit_surface_q;
	assign hit_distance = hit_distance_q;
endmodule

### src/rtn_mac.sv
// ----------------------------------------------------------------------------
// rtn_mac: serial multiply-accumulate unit
// Adds or subtracts x times a signed y, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rtn_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rtn_pkg::mac_cmd_t               cmd,
	input  logic signed [rtn_pkg::W-1:0]    x,
	input  logic        [rtn_pkg::YW-1:0]   y,
	output logic                            done,
	output logic signed [rtn_pkg::W-1:0]    acc
);
	localparam int CW = $clog2(rtn_pkg::YW);

	logic                       busy_q;
	logic                       done_q;
	logic [CW-1:0]              cnt_q;
	logic [rtn_pkg::W-1:0]      x_q;
	logic [rtn_pkg::YW-1:0]     y_q;
	logic                       neg_q;
	logic [rtn_pkg::W-1:0]      acc_q;
	logic                       last;
	logic                       sub;
	logic [rtn_pkg::W-1:0]      term;
	logic [rtn_pkg::W-1:0]      sum;

	// The top multiplier bit carries negative weight.
	assign last = (cnt_q == CW'(rtn_pkg::YW - 1));
	assign sub  = last ^ neg_q;
	assign term = y_q[0] ? x_q : '0;
	assign sum  = acc_q + (term ^ {rtn_pkg::W{sub}}) + rtn_pkg::W'(sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q   <= x;
			y_q   <= y;
			neg_q <= cmd.neg;
			if (cmd.clear) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q <= sum;
			x_q   <= x_q << 1;
			y_q   <= y_q >> 1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
endmodule

### src/rtn_div.sv
// ----------------------------------------------------------------------------
// rtn_div: restoring divider
// Produces one quotient bit per cycle from a partial remainder below d.
// ----------------------------------------------------------------------------
module rtn_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rtn_pkg::div_cmd_t             cmd,
	input  logic [rtn_pkg::W-1:0]         r0,
	input  logic [rtn_pkg::NW-1:0]        n,
	input  logic [rtn_pkg::W-1:0]         d,
	output logic                          done,
	output logic [rtn_pkg::NW-1:0]        q
);
	localparam int CW = $clog2(rtn_pkg::NW);

	logic                      busy_q;
	logic                      done_q;
	logic [CW-1:0]             cnt_q;
	logic [rtn_pkg::W-1:0]     r_q;
	logic [rtn_pkg::W-1:0]     d_q;
	logic [rtn_pkg::NW-1:0]    n_q;
	logic [rtn_pkg::W:0]       r2;
	logic [rtn_pkg::W:0]       diff;
	logic                      ge;

	// The numerator shifts out at the top while quotient bits enter below.
	assign r2   = {r_q, n_q[rtn_pkg::NW-1]};
	assign diff = r2 - {1'b0, d_q};
	assign ge   = (r2 >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(rtn_pkg::NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r_q <= r0;
			d_q <= d;
			n_q <= n;
		end else if (busy_q) begin
			r_q <= ge ? diff[rtn_pkg::W-1:0] : r2[rtn_pkg::W-1:0];
			n_q <= {n_q[rtn_pkg::NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = n_q;
endmodule

### dv/rtn_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtn_checker: prediction and comparison for the nearest-hit block
// Follows every input transaction, works out the running answer and compares
// it with each output transaction in order.
// ----------------------------------------------------------------------------
module rtn_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               func,
	input  logic signed [31:0] pt_a_x,
	input  logic signed [31:0] pt_a_y,
	input  logic signed [31:0] pt_a_z,
	input  logic signed [31:0] pt_b_x,
	input  logic signed [31:0] pt_b_y,
	input  logic signed [31:0] pt_b_z,
	input  logic signed [31:0] pt_c_x,
	input  logic signed [31:0] pt_c_y,
	input  logic signed [31:0] pt_c_z,
	input  logic signed [12:0] surface_index,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               hit_found,
	input  logic [11:0]        hit_surface,
	input  logic [30:0]        hit_distance,
	output int                 fails,
	output int                 pending,
	output int                 n_checked,
	output int                 n_hits
);

	typedef struct packed {
		logic        found;
		logic [11:0] surf;
		logic [30:0] distance;
	} answer_t;

	localparam logic [127:0] A_MIN =
		((128'd1 << (rtn_pkg::DIR_FRAC_BITS + 2 * rtn_pkg::COORD_FRAC_BITS))
		+ 128'd999999999) / 128'd1000000000;
	localparam logic [63:0] GUARD = ((64'd1 << rtn_pkg::COORD_FRAC_BITS) + 64'd999999)
		/ 64'd1000000;

	answer_t answers_due[$];

	// Predicted state of the segment and the best hit so far.
	logic signed [31:0] seg_org [3];
	logic signed [31:0] seg_dir [3];
	logic [31:0]        best_dist;
	logic [11:0]        best_surf;
	logic               best_hit;
	logic [12:0]        skip_idx;
	logic               seg_ok;

	task automatic load_segment(input logic signed [31:0] pa [3],
		input logic signed [31:0] pb [3], input logic [12:0] si);
		logic signed [63:0] d [3];
		logic [63:0] mag [3];
		logic [127:0] sq, cand;
		logic [63:0] len, r;
		logic any;
		sq = 0;
		any = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = 64'(pb[i]) - 64'(pa[i]);
			mag[i] = d[i][63] ? -d[i] : d[i];
			sq += 128'(mag[i]) * 128'(mag[i]);
			if (d[i] != 0) any = 1;
			seg_org[i] = pa[i];
		end
		if (any) begin
			len = 0;
			for (int b = 33; b >= 0; b--) begin
				cand = 128'(len | (64'd1 << b));
				if (cand * cand <= sq) len = cand[63:0];
			end
			for (int i = 0; i < 3; i++) begin
				r = ((mag[i] << rtn_pkg::DIR_FRAC_BITS) + len / 2) / len;
				if (r > (64'd1 << rtn_pkg::DIR_FRAC_BITS)) r = 64'd1 << rtn_pkg::DIR_FRAC_BITS;
				seg_dir[i] = d[i][63] ? -r[31:0] : r[31:0];
			end
			best_dist = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
		end else begin
			for (int i = 0; i < 3; i++) seg_dir[i] = 0;
			best_dist = 0;
		end
		best_hit = 0;
		best_surf = 0;
		skip_idx = si;
		seg_ok = any;
	endtask

	task automatic test_facet(input logic signed [31:0] pa [3],
		input logic signed [31:0] pb [3], input logic signed [31:0] pc [3],
		input logic [12:0] si);
		logic signed [127:0] e1 [3], e2 [3], s [3], dv [3], h [3], q [3];
		logic signed [127:0] a, u, v, t;
		logic [127:0] q0;
		logic [159:0] tq;
		logic [63:0] dist_val;
		int j, k;
		if (!seg_ok || si[12] || si == skip_idx) return;
		for (int i = 0; i < 3; i++) begin
			e1[i] = 128'(pb[i]) - 128'(pa[i]);
			e2[i] = 128'(pc[i]) - 128'(pa[i]);
			s[i]  = 128'(seg_org[i]) - 128'(pa[i]);
			dv[i] = 128'(seg_dir[i]);
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			h[i] = dv[j] * e2[k] - dv[k] * e2[j];
			q[i] = s[j] * e1[k] - s[k] * e1[j];
		end
		a = 0; u = 0; v = 0; t = 0;
		for (int i = 0; i < 3; i++) begin
			a += h[i] * e1[i];
			u += h[i] * s[i];
			v += q[i] * dv[i];
			t += q[i] * e2[i];
		end
		if (a < 0) begin
			a = -a; u = -u; v = -v; t = -t;
		end
		if ($unsigned(a) < A_MIN) return;
		if (u < 0 || u > a) return;
		if (v < 0 || u + v > a) return;
		if (t <= 0) return;
		q0 = $unsigned(t) / $unsigned(a);
		if (q0 >= (128'd1 << 33)) return;
		tq = (160'($unsigned(t)) << rtn_pkg::DIR_FRAC_BITS) / 160'($unsigned(a));
		dist_val = tq[63:0];
		if (dist_val < GUARD || dist_val + GUARD >= 64'(best_dist)) return;
		best_dist = dist_val[31:0];
		best_surf = si[11:0];
		best_hit = 1;
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want, n_checked);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				seg_org[i] = 0;
				seg_dir[i] = 0;
			end
			best_dist = 0; best_surf = 0; best_hit = 0;
			skip_idx = 13'h1FFF; seg_ok = 0;
			answers_due.delete();
			fails = 0; pending = 0; n_checked = 0; n_hits = 0;
		end else begin
			logic signed [31:0] pa [3], pb [3], pc [3];
			answer_t got, want;
			if (out_valid && out_ready) begin
				got = '{hit_found, hit_surface, hit_distance};
				if (answers_due.size() == 0) begin
					report("output transaction with nothing expected",
						32'(got.distance), '0);
				end else begin
					want = answers_due.pop_front();
					if (got.found != want.found) report("hit_found", got.found, want.found);
					if (got.surf != want.surf) report("hit_surface", got.surf, want.surf);
					if (got.distance != want.distance)
						report("hit_distance", got.distance, want.distance);
					if (want.found) n_hits++;
				end
				n_checked++;
			end
			if (in_valid && in_ready) begin
				pa = '{pt_a_x, pt_a_y, pt_a_z};
				pb = '{pt_b_x, pt_b_y, pt_b_z};
				pc = '{pt_c_x, pt_c_y, pt_c_z};
				if (func) test_facet(pa, pb, pc, surface_index);
				else load_segment(pa, pb, surface_index);
				want.found = best_hit;
				want.surf = best_surf;
				want.distance = (best_dist > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : best_dist[30:0];
				answers_due.insert(answers_due.size(), want);
			end
			pending = answers_due.size();
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the nearest-hit block
// Drives directed and random segments and triangles with random idling on
// both channels; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int N_RANDOM   = 630;
	localparam int CYCLE_CAP  = 6000000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic               func = 0;
	logic signed [31:0] pt_a_x = 0, pt_a_y = 0, pt_a_z = 0;
	logic signed [31:0] pt_b_x = 0, pt_b_y = 0, pt_b_z = 0;
	logic signed [31:0] pt_c_x = 0, pt_c_y = 0, pt_c_z = 0;
	logic signed [12:0] surface_index = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic               hit_found;
	logic [11:0]        hit_surface;
	logic [30:0]        hit_distance;

	int fails, pending, n_checked, n_hits;
	int sent = 0;
	int cycles = 0;
	logic hold_off = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	ray_triangle_nearest_hit DUT (.*);

	rtn_checker u_checker (.*);

	// The run is bounded whatever the block does.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The receiver takes results with random stalls, mostly short, sometimes
	// long, and is held off entirely while the hold-off process says so.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready = 0;
			end else if (stall > 0) begin
				out_ready = 0;
				stall--;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:74]:  out_ready = 1;
					[75:94]: begin out_ready = 0; stall = $urandom_range(0, 3); end
					default: begin out_ready = 0; stall = $urandom_range(50, 400); end
				endcase
			end
		end
	end

	// Once, mid-run, the receiver refuses results for a long stretch while
	// the sender keeps offering, so that the block backs up to its input.
	initial begin
		wait (sent >= 300);
		@(negedge clk);
		hold_off = 1;
		repeat (4000) @(negedge clk);
		hold_off = 0;
	end

	function automatic logic signed [31:0] metres(input int m);
		return 32'(m) <<< 16;
	endfunction

	function automatic logic signed [31:0] span(input int half);
		return 32'($signed($urandom_range(0, 2 * half))) - 32'(half);
	endfunction

	// Offers one transaction after a random gap and waits until it is taken.
	// The payload is set at a falling edge and in_ready, which is stable
	// there, tells whether the next rising edge accepts it.
	task automatic offer(input logic f,
		input logic signed [31:0] ax, ay, az, bx, by, bz, cx, cy, cz,
		input logic signed [12:0] si);
		int gap;
		case ($urandom_range(0, 99)) inside
			[0:69]:  gap = 0;
			[70:94]: gap = $urandom_range(1, 3);
			default: gap = $urandom_range(20, 200);
		endcase
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		func = f;
		pt_a_x = ax; pt_a_y = ay; pt_a_z = az;
		pt_b_x = bx; pt_b_y = by; pt_b_z = bz;
		pt_c_x = cx; pt_c_y = cy; pt_c_z = cz;
		surface_index = si;
		in_valid = 1;
		while (!in_ready) @(negedge clk);
		@(negedge clk);
		sent++;
	endtask

	// A triangle whose centroid lies at step k of 16 along the segment; steps
	// outside 0..16 fall before the start or past the end.
	task automatic offer_crossing(input logic signed [31:0] a [3],
		input logic signed [31:0] b [3], input int k, input logic signed [12:0] si,
		input int spread);
		logic signed [31:0] p [3], o1 [3], o2 [3];
		for (int i = 0; i < 3; i++) begin
			p[i] = a[i] + 32'((64'(b[i]) - 64'(a[i])) * k / 16);
			o1[i] = span(spread);
			o2[i] = span(spread);
		end
		offer(1, p[0] + o1[0], p[1] + o1[1], p[2] + o1[2],
			p[0] + o2[0], p[1] + o2[1], p[2] + o2[2],
			p[0] - o1[0] - o2[0], p[1] - o1[1] - o2[1], p[2] - o1[2] - o2[2], si);
	endtask

	initial begin
		logic signed [31:0] ra [3], rb [3];
		logic signed [12:0] skip;
		int n_tri;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// A triangle before any segment is loaded can never hit.
		offer(1, metres(5), metres(-1), metres(-1), metres(5), metres(3), metres(-1),
			metres(5), metres(-1), metres(3), 7);
		// A segment of zero length, then a triangle across it: no hit.
		offer(0, metres(1), metres(1), metres(1), metres(1), metres(1), metres(1),
			0, 0, 0, -1);
		offer(1, metres(1), metres(0), metres(0), metres(1), metres(3), metres(0),
			metres(1), metres(0), metres(3), 5);
		// Ten metres along x, skipping surface 3.
		offer(0, 0, 0, 0, metres(10), 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, -1, 3);
		offer(1, metres(5), metres(-1), metres(-1), metres(5), metres(3), metres(-1),
			metres(5), metres(-1), metres(3), 7);
		// Farther than the current best: no update.
		offer(1, metres(7), metres(-1), metres(-1), metres(7), metres(3), metres(-1),
			metres(7), metres(-1), metres(3), 8);
		// Nearer: updates, with the top surface index.
		offer(1, metres(2), metres(-1), metres(-1), metres(2), metres(3), metres(-1),
			metres(2), metres(-1), metres(3), 4095);
		// Skipped surface, negative indices and the most negative index.
		offer(1, metres(1), metres(-1), metres(-1), metres(1), metres(3), metres(-1),
			metres(1), metres(-1), metres(3), 3);
		offer(1, metres(1), metres(-1), metres(-1), metres(1), metres(3), metres(-1),
			metres(1), metres(-1), metres(3), -1);
		offer(1, metres(1), metres(-1), metres(-1), metres(1), metres(3), metres(-1),
			metres(1), metres(-1), metres(3), -4096);
		// Degenerate triangle, and one parallel to the segment.
		offer(1, metres(1), metres(1), metres(1), metres(1), metres(1), metres(1),
			metres(1), metres(1), metres(1), 0);
		offer(1, metres(0), metres(1), metres(-1), metres(9), metres(1), metres(-1),
			metres(0), metres(1), metres(3), 0);
		// Triangle behind the start, and one sitting exactly at the start.
		offer(1, metres(-2), metres(-1), metres(-1), metres(-2), metres(3), metres(-1),
			metres(-2), metres(-1), metres(3), 1);
		offer(1, 0, metres(-1), metres(-1), 0, metres(3), metres(-1),
			0, metres(-1), metres(3), 2);
		// Longest segments: corner to corner, and along one axis; the length
		// saturates in the state and in the reported distance.
		offer(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 4095);
		offer(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 12);
		offer(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, -4096);
		offer(1, 0, metres(-1), metres(-1), 0, metres(3), metres(-1),
			0, metres(-1), metres(3), 4094);

		// Random part: mostly a segment followed by a handful of triangles
		// placed across it, with whole-random noise mixed in.
		while (sent < 18 + N_RANDOM) begin
			if ($urandom_range(0, 99) < 15) begin
				offer($urandom_range(0, 1), $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					13'($urandom));
			end else begin
				for (int i = 0; i < 3; i++) begin
					ra[i] = span(1 << 24);
					rb[i] = ($urandom_range(0, 19) == 0) ? ra[i] : span(1 << 24);
				end
				skip = ($urandom_range(0, 3) == 0) ? -1 : 13'($urandom_range(0, 15));
				offer(0, ra[0], ra[1], ra[2], rb[0], rb[1], rb[2],
					$urandom, $urandom, $urandom, skip);
				n_tri = $urandom_range(1, 6);
				for (int n = 0; n < n_tri; n++)
					offer_crossing(ra, rb, $urandom_range(0, 18) - 1,
						($urandom_range(0, 5) == 0) ? skip : 13'($urandom_range(0, 15)),
						1 << $urandom_range(4, 22));
			end
		end
		in_valid = 0;

		wait (pending == 0);
		repeat (1000) @(negedge clk);
		$display("%0d transactions sent, %0d results checked, %0d with a hit found",
			sent, n_checked, n_hits);
		if (fails == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### filelist.f
src/rtn_pkg.sv
src/rtn_mac.sv
src/rtn_div.sv
src/ray_triangle_nearest_hit.sv
dv/rtn_checker.sv
dv/tb_top.sv
